FILE: rtl/qpd_pkg.sv
package qpd_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int DEG_WIDTH   = 9;
   localparam int PROD_WIDTH  = COUNT_WIDTH + DEG_WIDTH;
   localparam int STEP_WIDTH  = 2;
   localparam int PHASE_WIDTH = 2;
   localparam int ANGLE_STEPS = 2 * DEG_WIDTH;
   localparam int SEQ_WIDTH   = $clog2(ANGLE_STEPS);
   localparam int CSR_AWIDTH  = 3;
   localparam int CSR_DWIDTH  = 32;

   localparam logic [DEG_WIDTH-1:0]   DEG_FULL  = DEG_WIDTH'(360);
   localparam logic [COUNT_WIDTH-1:0] RESET_RES = COUNT_WIDTH'(448);

   localparam logic signed [STEP_WIDTH-1:0] STEP_FWD  = 2'sb01;
   localparam logic signed [STEP_WIDTH-1:0] STEP_BACK = 2'sb11;
   localparam logic signed [STEP_WIDTH-1:0] STEP_NONE = 2'sb00;

   localparam logic [CSR_AWIDTH-3:0] REG_COUNTS_PER_REV = '0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUSY,
      ST_HOLD
   } state_type;

   // next gray phase in the forward direction
   function automatic logic [PHASE_WIDTH-1:0] fwd_next(input logic [PHASE_WIDTH-1:0] prev);
      logic [PHASE_WIDTH-1:0] nxt;
      unique case (prev)
         2'b00:   nxt = 2'b01;
         2'b01:   nxt = 2'b11;
         2'b11:   nxt = 2'b10;
         default: nxt = 2'b00;
      endcase
      return nxt;
   endfunction

endpackage

FILE: rtl/qpd_req_if.sv
interface qpd_req_if import qpd_pkg::*; ();
   logic valid;
   logic ready;
   logic cmd;
   logic phase_a;
   logic phase_b;

   modport source (output valid, output cmd, output phase_a, output phase_b, input ready);
   modport sink   (input valid, input cmd, input phase_a, input phase_b, output ready);
endinterface

FILE: rtl/qpd_rsp_if.sv
interface qpd_rsp_if import qpd_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic [COUNT_WIDTH-1:0]         position_count;
   logic [DEG_WIDTH-1:0]           angle_degrees;
   logic signed [STEP_WIDTH-1:0]   step_taken;

   modport source (output valid, output position_count, output angle_degrees,
                   output step_taken, input ready);
   modport sink   (input valid, input position_count, input angle_degrees,
                   input step_taken, output ready);
endinterface

FILE: rtl/quadrature_position_decoder_unit.sv
// quadrature position decoder, x4 counting
// req_chan: one word per encoder event; cmd low is a sample of channels a and b,
// cmd high is a reference pulse that clears the position
// rsp_chan: one word per request with position count, angle in degrees and step
// csr port: apb write of counts_per_rev at byte address 0, reads return it
// the count updates at the accept edge, a start register then loads the angle unit,
// which multiplies by 360 and divides by counts_per_rev in a bit-serial shift-add
// and restoring divide unit, then the result goes to the output register
// the serial angle unit handles one word at a time; no request is taken while it is busy
// a new request is taken as soon as the previous result sits in the output
// register, so a stalled receiver delays only the following result
// reset: position and last phase clear, counts_per_rev returns to 448,
// no response is pending
// a response held by the receiver stays valid and unchanged until taken
module quadrature_position_decoder_unit import qpd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   qpd_req_if.sink               req_chan,
   qpd_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_AWIDTH-1:0] csr_paddr,
   input  logic [CSR_DWIDTH-1:0] csr_pwdata,
   output logic [CSR_DWIDTH-1:0] csr_prdata,
   output logic                  csr_pready
);

   state_type                     state_ff, state_in;
   logic [COUNT_WIDTH-1:0]        counts_ff, counts_in;
   logic                          start_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [COUNT_WIDTH-1:0]        rsp_pos_ff, rsp_pos_in;
   logic [DEG_WIDTH-1:0]          rsp_angle_ff, rsp_angle_in;
   logic signed [STEP_WIDTH-1:0]  rsp_step_ff, rsp_step_in;
   logic                          accept;
   logic                          csr_write;
   logic                          reg_hit;
   logic [COUNT_WIDTH-1:0]        modulus;
   logic [COUNT_WIDTH-1:0]        position;
   logic signed [STEP_WIDTH-1:0]  step;
   logic                          angle_done;
   logic [DEG_WIDTH-1:0]          angle;
   logic                          slot_free;
   logic                          load;

   assign csr_pready = 1'b1;
   assign reg_hit    = csr_paddr[CSR_AWIDTH-1:2] == REG_COUNTS_PER_REV;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign counts_in  = (csr_write && reg_hit) ? csr_pwdata[COUNT_WIDTH-1:0] : counts_ff;
   assign csr_prdata = reg_hit ? CSR_DWIDTH'(counts_ff) : '0;
   assign modulus    = (counts_ff == '0) ? COUNT_WIDTH'(1) : counts_ff;

   assign accept    = req_chan.valid && req_chan.ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   qpd_phase_counter u_counter (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .cmd      (req_chan.cmd),
      .phase_a  (req_chan.phase_a),
      .phase_b  (req_chan.phase_b),
      .modulus  (modulus),
      .position (position),
      .step     (step)
   );

   qpd_angle_unit u_angle (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .position (position),
      .modulus  (modulus),
      .done     (angle_done),
      .angle    (angle)
   );

   always_comb begin
      state_in       = state_ff;
      req_chan.ready = 1'b0;
      load           = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (angle_done) begin
               if (slot_free) begin
                  load     = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_angle_in = rsp_angle_ff;
      rsp_step_in  = rsp_step_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_pos_in   = position;
         rsp_angle_in = angle;
         rsp_step_in  = step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         counts_ff    <= RESET_RES;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counts_ff    <= counts_in;
         start_ff     <= accept;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_pos_ff   <= rsp_pos_in;
      rsp_angle_ff <= rsp_angle_in;
      rsp_step_ff  <= rsp_step_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.position_count = rsp_pos_ff;
   assign rsp_chan.angle_degrees  = rsp_angle_ff;
   assign rsp_chan.step_taken     = rsp_step_ff;

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_BUSY && start_ff))
      else $error("accepted word did not start the angle unit");

   a_done_when_busy: assert property (@(posedge clock) disable iff (reset)
      angle_done |-> (state_ff == ST_BUSY))
      else $error("angle unit finished outside a busy period");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_angle_ff < DEG_FULL))
      else $error("angle out of range");

   a_step_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_step_ff != 2'sb10))
      else $error("invalid step code");
`endif

endmodule

FILE: rtl/qpd_phase_counter.sv
module qpd_phase_counter import qpd_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic                         cmd,
   input  logic                         phase_a,
   input  logic                         phase_b,
   input  logic [COUNT_WIDTH-1:0]       modulus,
   output logic [COUNT_WIDTH-1:0]       position,
   output logic signed [STEP_WIDTH-1:0] step
);

   logic [PHASE_WIDTH-1:0]        last_phase_ff, last_phase_in;
   logic [COUNT_WIDTH-1:0]        position_ff, position_in;
   logic signed [STEP_WIDTH-1:0]  step_ff, step_in;
   logic [PHASE_WIDTH-1:0]        now;
   logic [COUNT_WIDTH:0]          moved;

   always_comb begin
      now           = {phase_a, phase_b};
      last_phase_in = last_phase_ff;
      position_in   = position_ff;
      step_in       = step_ff;
      moved         = {1'b0, position_ff};
      if (accept) begin
         if (cmd) begin
            position_in = '0;
            step_in     = STEP_NONE;
         end else begin
            last_phase_in = now;
            priority if (fwd_next(last_phase_ff) == now) begin
               step_in = STEP_FWD;
               moved   = {1'b0, position_ff} + (COUNT_WIDTH+1)'(1);
            end else if (fwd_next(now) == last_phase_ff) begin
               step_in = STEP_BACK;
               moved   = {1'b0, position_ff} - (COUNT_WIDTH+1)'(1);
            end else begin
               step_in = STEP_NONE;
            end
            priority if (step_in == STEP_BACK && position_ff == '0) begin
               position_in = modulus - COUNT_WIDTH'(1);
            end else if (moved >= {1'b0, modulus}) begin
               position_in = '0;
            end else begin
               position_in = moved[COUNT_WIDTH-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_phase_ff <= '0;
         position_ff   <= '0;
      end else begin
         last_phase_ff <= last_phase_in;
         position_ff   <= position_in;
      end
      step_ff <= step_in;
   end

   assign position = position_ff;
   assign step     = step_ff;

endmodule

FILE: rtl/qpd_angle_unit.sv
module qpd_angle_unit import qpd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [COUNT_WIDTH-1:0] position,
   input  logic [COUNT_WIDTH-1:0] modulus,
   output logic                   done,
   output logic [DEG_WIDTH-1:0]   angle
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [SEQ_WIDTH-1:0]   seq_ff, seq_in;
   logic [COUNT_WIDTH-1:0] pos_ff, pos_in;
   logic [DEG_WIDTH-1:0]   mul_sr_ff, mul_sr_in;
   logic [PROD_WIDTH-1:0]  acc_ff, acc_in;
   logic [COUNT_WIDTH-1:0] rem_ff, rem_in;
   logic [COUNT_WIDTH-1:0] rem_cur;
   logic [COUNT_WIDTH:0]   trial;
   logic                   q_bit;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      seq_in    = seq_ff;
      pos_in    = pos_ff;
      mul_sr_in = mul_sr_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      rem_cur   = (seq_ff == SEQ_WIDTH'(DEG_WIDTH)) ?
                  acc_ff[PROD_WIDTH-1:DEG_WIDTH] : rem_ff;
      trial     = {rem_cur, acc_ff[DEG_WIDTH-1]};
      q_bit     = trial >= {1'b0, modulus};
      if (start) begin
         busy_in   = 1'b1;
         seq_in    = '0;
         pos_in    = position;
         mul_sr_in = DEG_FULL;
         acc_in    = '0;
      end else if (busy_ff) begin
         if (seq_ff < SEQ_WIDTH'(DEG_WIDTH)) begin
            // shift-add multiply, one bit of the constant per cycle
            acc_in    = {acc_ff[PROD_WIDTH-2:0], 1'b0} +
                        (mul_sr_ff[DEG_WIDTH-1] ? PROD_WIDTH'(pos_ff) : '0);
            mul_sr_in = {mul_sr_ff[DEG_WIDTH-2:0], 1'b0};
         end else begin
            // restoring division, one quotient bit per cycle
            rem_in = q_bit ? COUNT_WIDTH'(trial - {1'b0, modulus})
                           : trial[COUNT_WIDTH-1:0];
            acc_in = {acc_ff[PROD_WIDTH-1:DEG_WIDTH], acc_ff[DEG_WIDTH-2:0], q_bit};
         end
         seq_in = seq_ff + SEQ_WIDTH'(1);
         if (seq_ff == SEQ_WIDTH'(ANGLE_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         seq_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         seq_ff  <= seq_in;
      end
      pos_ff    <= pos_in;
      mul_sr_ff <= mul_sr_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
   end

   assign done  = done_ff;
   assign angle = acc_ff[DEG_WIDTH-1:0];

endmodule
